@@ hw/rtl/mbpu_pkg.sv @@
`default_nettype none

package mbpu_pkg;

    // storage geometry
    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 5);
    localparam int SUM_W        = CNT_W + 1;
    localparam int BANKS        = 4;
    localparam int ROW_W        = ADDR_W - 2;
    localparam int ROWS         = BUFFER_DEPTH / BANKS;
    localparam int RCNT_MAX     = BUFFER_DEPTH + 4;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_OVF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 2'd1;

    // queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // operation codes
    localparam logic [3:0] OP_CLEAR    = 4'd0;
    localparam logic [3:0] OP_BEGIN_RD = 4'd1;
    localparam logic [3:0] OP_WR_BYTE  = 4'd2;
    localparam logic [3:0] OP_WR_SHORT = 4'd3;
    localparam logic [3:0] OP_WR_LONG  = 4'd4;
    localparam logic [3:0] OP_RD_CHAR  = 4'd5;
    localparam logic [3:0] OP_RD_BYTE  = 4'd6;
    localparam logic [3:0] OP_RD_SHORT = 4'd7;
    localparam logic [3:0] OP_RD_LONG  = 4'd8;

    // decoded command kinds
    localparam logic [2:0] K_NOP   = 3'd0;
    localparam logic [2:0] K_CLEAR = 3'd1;
    localparam logic [2:0] K_BEGIN = 3'd2;
    localparam logic [2:0] K_WRITE = 3'd3;
    localparam logic [2:0] K_READ  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OVF_CLEARED = 2'd1;
    localparam logic [1:0] ST_FATAL       = 2'd2;
    localparam logic [1:0] ST_READ_PAST   = 2'd3;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic               overflowed;
        logic [10:0]        bytes_written;
        logic [10:0]        bytes_read;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  len;
        logic        sext;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic             allow_ovf;
        logic [CNT_W-1:0] size;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/mbpu_front.sv @@
`default_nettype none

module mbpu_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   push,
    output logic                  full,
    input  mbpu_pkg::t_in_item    i_in_item,
    output logic                  o_cmd_valid,
    output mbpu_pkg::t_cmd        o_cmd,
    input  wire                   i_cmd_deq
);

    mbpu_pkg::t_cmd r_q [mbpu_pkg::CMDQ_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    mbpu_pkg::t_cmd dec;
    logic           do_push;
    logic           do_pop;

    // classify the operation into kind, length and sign handling
    always_comb begin
        dec       = '0;
        dec.value = i_in_item.write_value;
        case (i_in_item.operation)
            mbpu_pkg::OP_CLEAR:    dec.kind = mbpu_pkg::K_CLEAR;
            mbpu_pkg::OP_BEGIN_RD: dec.kind = mbpu_pkg::K_BEGIN;
            mbpu_pkg::OP_WR_BYTE: begin
                dec.kind = mbpu_pkg::K_WRITE;
                dec.len  = 3'd1;
            end
            mbpu_pkg::OP_WR_SHORT: begin
                dec.kind = mbpu_pkg::K_WRITE;
                dec.len  = 3'd2;
            end
            mbpu_pkg::OP_WR_LONG: begin
                dec.kind = mbpu_pkg::K_WRITE;
                dec.len  = 3'd4;
            end
            mbpu_pkg::OP_RD_CHAR: begin
                dec.kind = mbpu_pkg::K_READ;
                dec.len  = 3'd1;
                dec.sext = 1'b1;
            end
            mbpu_pkg::OP_RD_BYTE: begin
                dec.kind = mbpu_pkg::K_READ;
                dec.len  = 3'd1;
            end
            mbpu_pkg::OP_RD_SHORT: begin
                dec.kind = mbpu_pkg::K_READ;
                dec.len  = 3'd2;
                dec.sext = 1'b1;
            end
            mbpu_pkg::OP_RD_LONG: begin
                dec.kind = mbpu_pkg::K_READ;
                dec.len  = 3'd4;
            end
            default:               dec.kind = mbpu_pkg::K_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'(mbpu_pkg::CMDQ_DEPTH));
    assign do_push     = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign do_pop      = i_cmd_deq && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mbpu_back.sv @@
`default_nettype none

module mbpu_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  mbpu_pkg::t_cfg                      i_cfg,
    input  wire                                 i_cmd_valid,
    input  mbpu_pkg::t_cmd                      i_cmd,
    output logic                                o_cmd_deq,
    input  wire  [mbpu_pkg::OUTQ_CNT_W-1:0]     i_outq_level,
    output logic                                o_res_valid,
    output mbpu_pkg::t_out_item                 o_res
);

    localparam int CW = mbpu_pkg::CNT_W;
    localparam int SW = mbpu_pkg::SUM_W;
    localparam int AW = mbpu_pkg::ADDR_W;
    localparam int RW = mbpu_pkg::ROW_W;

    // architectural state
    logic [CW-1:0] r_wcnt;
    logic [CW-1:0] r_rcnt;
    logic          r_ovf;
    logic [CW-1:0] n_wcnt;
    logic [CW-1:0] n_rcnt;
    logic          n_ovf;

    // result stage
    logic          r_rv;
    logic          r_rd;
    logic          r_ok;
    logic [2:0]    r_len;
    logic          r_sext;
    logic [1:0]    r_a0;
    logic [1:0]    r_status;

    logic          fire;
    logic [1:0]    status;
    logic          wr_en;
    logic          rd_ok;
    logic [AW-1:0] acc_addr;
    logic [SW-1:0] wc_sum;
    logic [SW-1:0] rc_sum;
    logic [SW-1:0] size_x;
    logic [SW-1:0] len_x;
    logic [7:0]    bank_q [mbpu_pkg::BANKS];
    logic [7:0]    byt [4];
    logic [31:0]   raw;
    logic [31:0]   val;

    // one result slot is held back for the item in the result stage
    assign fire = i_cmd_valid
        && ((i_outq_level + mbpu_pkg::OUTQ_CNT_W'(r_rv))
            < mbpu_pkg::OUTQ_CNT_W'(mbpu_pkg::OUTQ_DEPTH));
    assign o_cmd_deq = fire;

    assign size_x = {1'b0, i_cfg.size};
    assign len_x  = SW'(i_cmd.len);
    assign wc_sum = {1'b0, r_wcnt} + len_x;
    assign rc_sum = {1'b0, r_rcnt} + len_x;

    always_comb begin
        n_wcnt   = r_wcnt;
        n_rcnt   = r_rcnt;
        n_ovf    = r_ovf;
        status   = mbpu_pkg::ST_OK;
        wr_en    = 1'b0;
        rd_ok    = 1'b0;
        acc_addr = r_wcnt[AW-1:0];
        case (i_cmd.kind)
            mbpu_pkg::K_CLEAR: begin
                n_wcnt = '0;
                n_ovf  = 1'b0;
            end
            mbpu_pkg::K_BEGIN: begin
                n_rcnt = '0;
            end
            mbpu_pkg::K_WRITE: begin
                if (wc_sum > size_x) begin
                    if (!i_cfg.allow_ovf || (len_x > size_x)) begin
                        status = mbpu_pkg::ST_FATAL;
                    end else begin
                        // wrap: drop contents and land at the start
                        status   = mbpu_pkg::ST_OVF_CLEARED;
                        n_ovf    = 1'b1;
                        wr_en    = 1'b1;
                        acc_addr = '0;
                        n_wcnt   = CW'(i_cmd.len);
                    end
                end else begin
                    wr_en  = 1'b1;
                    n_wcnt = wc_sum[CW-1:0];
                end
            end
            mbpu_pkg::K_READ: begin
                acc_addr = r_rcnt[AW-1:0];
                rd_ok    = (rc_sum <= {1'b0, r_wcnt});
                status   = rd_ok ? mbpu_pkg::ST_OK : mbpu_pkg::ST_READ_PAST;
                if (rc_sum > SW'(mbpu_pkg::RCNT_MAX)) begin
                    n_rcnt = CW'(mbpu_pkg::RCNT_MAX);
                end else begin
                    n_rcnt = rc_sum[CW-1:0];
                end
            end
            default: begin
                status = mbpu_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
            r_rcnt <= '0;
            r_ovf  <= 1'b0;
            r_rv   <= 1'b0;
        end else begin
            r_rv <= fire;
            if (fire) begin
                r_wcnt <= n_wcnt;
                r_rcnt <= n_rcnt;
                r_ovf  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd     <= (i_cmd.kind == mbpu_pkg::K_READ);
            r_ok     <= rd_ok;
            r_len    <= i_cmd.len;
            r_sext   <= i_cmd.sext;
            r_a0     <= acc_addr[1:0];
            r_status <= status;
        end
    end

    // byte banks: each bank serves one byte of an unaligned access
    for (genvar gb = 0; gb < mbpu_pkg::BANKS; gb++) begin : g_bank
        logic [7:0]    mem [mbpu_pkg::ROWS];
        logic [1:0]    off;
        logic [RW-1:0] row;
        logic          we;
        logic          re;
        logic [7:0]    wdat;

        assign off  = 2'(gb) - acc_addr[1:0];
        assign row  = acc_addr[AW-1:2]
            + {{(RW-1){1'b0}}, (2'(gb) < acc_addr[1:0])};
        assign we   = fire && wr_en && ({1'b0, off} < i_cmd.len);
        assign re   = fire && (i_cmd.kind == mbpu_pkg::K_READ);
        assign wdat = i_cmd.value[{off, 3'b000} +: 8];

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[row] <= wdat;
            end
            if (re) begin
                bank_q[gb] <= mem[row];
            end
        end
    end

    // gather bytes back into little-endian order
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            byt[i] = bank_q[2'(r_a0 + 2'(i))];
        end
        raw = {byt[3], byt[2], byt[1], byt[0]};
        case (r_len)
            3'd1:    val = {{24{r_sext & byt[0][7]}}, byt[0]};
            3'd2:    val = {{16{r_sext & byt[1][7]}}, byt[1], byt[0]};
            default: val = raw;
        endcase
    end

    // counters have not moved yet for the next item when this one is stored
    assign o_res_valid           = r_rv;
    assign o_res.read_value      = !r_rd ? '0 : (r_ok ? val : '1);
    assign o_res.status          = r_status;
    assign o_res.overflowed      = r_ovf;
    assign o_res.bytes_written   = r_wcnt;
    assign o_res.bytes_read      = r_rcnt;

endmodule

`default_nettype wire

@@ hw/rtl/mbpu_outq.sv @@
`default_nettype none

module mbpu_outq (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_push,
    input  mbpu_pkg::t_out_item                 i_item,
    input  wire                                 pop,
    output logic                                empty,
    output mbpu_pkg::t_out_item                 o_out_item,
    output logic [mbpu_pkg::OUTQ_CNT_W-1:0]     o_level
);

    localparam int PW = mbpu_pkg::OUTQ_PTR_W;
    localparam int NW = mbpu_pkg::OUTQ_CNT_W;

    mbpu_pkg::t_out_item r_mem [mbpu_pkg::OUTQ_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [NW-1:0]       r_cnt;
    logic [NW-1:0]       n_cnt;
    logic                do_pop;

    assign empty      = (r_cnt == '0);
    assign do_pop     = pop && !empty;
    assign o_out_item = r_mem[r_rp];
    assign o_level    = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (do_pop && !i_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/message_buffer_pack_unpack.sv @@
// path: an item accepted into the input queue moves through the command queue and the
//   result stage register before it is pushed into the result queue
// throughput: one item per cycle while the result queue has room, set by the execute
//   stage and the one-access-per-cycle byte banks
// reset: synchronous active-low i_rst_n clears counts, flag and queues and sets config to its defaults;
//   the byte store is not cleared and needs no clearing pass
`default_nettype none

module message_buffer_pack_unpack (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item input queue side
    input  wire                                  push,
    output logic                                 full,
    input  mbpu_pkg::t_in_item                   i_in_item,
    // result queue side
    output logic                                 empty,
    input  wire                                  pop,
    output mbpu_pkg::t_out_item                  o_out_item,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [mbpu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [mbpu_pkg::CFG_W-1:0]           i_cfg_wdata
);

    // configuration registers
    logic                       r_allow_ovf;
    logic [mbpu_pkg::CNT_W-1:0] r_size;
    mbpu_pkg::t_cfg             cfg;

    // front to back command path
    logic                       cmd_valid;
    mbpu_pkg::t_cmd             cmd;
    logic                       cmd_deq;

    // back to result queue
    logic                                res_valid;
    mbpu_pkg::t_out_item                 res;
    logic [mbpu_pkg::OUTQ_CNT_W-1:0]     outq_level;

    // size above the store depth saturates to the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_ovf <= 1'b0;
            r_size      <= mbpu_pkg::CNT_W'(mbpu_pkg::BUFFER_DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbpu_pkg::CFG_ALLOW_OVF: begin
                    r_allow_ovf <= i_cfg_wdata[0];
                end
                mbpu_pkg::CFG_SIZE: begin
                    if (i_cfg_wdata > mbpu_pkg::CFG_W'(mbpu_pkg::BUFFER_DEPTH)) begin
                        r_size <= mbpu_pkg::CNT_W'(mbpu_pkg::BUFFER_DEPTH);
                    end else begin
                        r_size <= mbpu_pkg::CNT_W'(i_cfg_wdata);
                    end
                end
                default: begin
                    // indexes past the register list are dropped
                    r_allow_ovf <= r_allow_ovf;
                end
            endcase
        end
    end

    assign cfg.allow_ovf = r_allow_ovf;
    assign cfg.size      = r_size;

    // front: accept and decode items into a two-entry command queue
    mbpu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_deq   (cmd_deq)
    );

    // back: counters, overflow handling, banked byte store, result formatting
    mbpu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_deq    (cmd_deq),
        .i_outq_level (outq_level),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result queue; its level gives the back end credit to issue
    mbpu_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_item     (res),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item),
        .o_level    (outq_level)
    );

endmodule

`default_nettype wire
